// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the decoder modules.
// Each expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger implies the consequence at the next clock edge.
`define ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, result kinds and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W   = 21;
	localparam int KIND_W = 2;
	localparam int MAX_RES = 4;

	localparam logic [KIND_W-1:0] KIND_DECODED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RAW     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REPL    = 2'd2;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic [KIND_W-1:0] kind;
	} res_t;

	// All results caused by one byte, in delivery order from item[0].
	typedef struct packed {
		res_t [MAX_RES-1:0] item;
		logic [2:0]         count;
	} bundle_t;

	function automatic bundle_t push(bundle_t b, logic [CP_W-1:0] cp, logic [KIND_W-1:0] k);
		bundle_t r;
		r = b;
		r.item[b.count[1:0]].cp   = cp;
		r.item[b.count[1:0]].kind = k;
		r.count                   = b.count + 3'd1;
		return r;
	endfunction

endpackage

// ===== rtl/utf8d_in_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_in_if
// Byte channel into the decoder: one text byte per beat.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ===== rtl/utf8d_out_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_if
// Result channel out of the decoder: one code point per beat.
// ----------------------------------------------------------------------------
interface utf8d_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [1:0]  kind;
	logic        last_of_run;

	modport source (output valid, output code_point, output kind, output last_of_run,
		input ready);
	modport sink   (input valid, input code_point, input kind, input last_of_run,
		output ready);
endinterface

// ===== rtl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to Unicode code points.
// ----------------------------------------------------------------------------
// Usage:
//   text   : byte channel (data_byte, end_of_text); one byte per beat.
//   points : result channel (code_point, kind, last_of_run); one per beat.
//   A byte gives zero to four results; last_of_run marks the final one of
//   each byte. Bytes that only open or extend a sequence give none.
//   A byte passes through the input register and then the result register
//   before its first result beat. Throughput is one byte per cycle while
//   each byte gives at most one result and points does not stall; a byte
//   with more results holds the next byte in the input register until the
//   result register, draining one beat per ready cycle, is at its last.
//   A stall on points backs up into the input register and then drops
//   text.ready; nothing is lost or repeated.
//   Reset clears the pending sequence and both registers; no clearing pass.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	utf8d_in_if.sink  text,
	utf8d_out_if.source points
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       free;
	logic       advance;
	bundle_t    bundle;

	assign advance    = valid_s1 && free;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.data_byte;
			eot_s1  <= text.end_of_text;
		end
	end

	utf8d_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.advance     (advance),
		.bundle      (bundle)
	);

	utf8d_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.bundle (bundle),
		.free   (free),
		.points (points)
	);

endmodule

// ===== rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and single-pass decode of one byte into up to four results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_decode
	import utf8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  logic       advance,
	output bundle_t    bundle
);

	logic [2:0]      len_q, nxt_len;
	logic [1:0]      rcv_q, nxt_rcv;
	logic [CP_W-1:0] acc_q, nxt_acc, acc_c;
	logic [5:0]      held0_q, held1_q, nxt_held0, nxt_held1;
	logic            taken;
	bundle_t         res;

	always_comb begin
		res       = '0;
		nxt_len   = len_q;
		nxt_rcv   = rcv_q;
		nxt_acc   = acc_q;
		nxt_held0 = held0_q;
		nxt_held1 = held1_q;
		taken     = 1'b0;
		acc_c     = {acc_q[CP_W-7:0], data_byte[5:0]};

		if (len_q != 3'd0) begin
			if (data_byte[7:6] == 2'b10) begin
				taken = 1'b1;
				if (({1'b0, rcv_q} + 3'd2) >= len_q) begin
					res     = push(res, acc_c, KIND_DECODED);
					nxt_len = 3'd0;
					nxt_rcv = 2'd0;
					nxt_acc = '0;
				end else begin
					nxt_acc = acc_c;
					if (rcv_q[0]) begin
						nxt_held1 = data_byte[5:0];
					end else begin
						nxt_held0 = data_byte[5:0];
					end
					nxt_rcv = rcv_q + 2'd1;
				end
			end else begin
				// broken sequence: replacement, then held bytes raw
				res = push(res, CP_REPLACEMENT, KIND_REPL);
				if (rcv_q >= 2'd1) begin
					res = push(res, {13'd0, 2'b10, held0_q}, KIND_RAW);
				end
				if (rcv_q >= 2'd2) begin
					res = push(res, {13'd0, 2'b10, held1_q}, KIND_RAW);
				end
				nxt_len = 3'd0;
				nxt_rcv = 2'd0;
				nxt_acc = '0;
			end
		end

		if (!taken) begin
			if (!data_byte[7]) begin
				res = push(res, {13'd0, data_byte}, KIND_DECODED);
			end else if (data_byte[7:5] == 3'b110) begin
				nxt_len = 3'd2;
				nxt_acc = {16'd0, data_byte[4:0]};
			end else if (data_byte[7:4] == 4'b1110) begin
				nxt_len = 3'd3;
				nxt_acc = {17'd0, data_byte[3:0]};
			end else if (data_byte[7:3] == 5'b11110) begin
				nxt_len = 3'd4;
				nxt_acc = {18'd0, data_byte[2:0]};
			end else begin
				res = push(res, {13'd0, data_byte}, KIND_RAW);
			end
		end

		// end of text flushes whatever is still pending
		if (end_of_text && nxt_len != 3'd0) begin
			res = push(res, CP_REPLACEMENT, KIND_REPL);
			if (nxt_rcv >= 2'd1) begin
				res = push(res, {13'd0, 2'b10, nxt_held0}, KIND_RAW);
			end
			if (nxt_rcv >= 2'd2) begin
				res = push(res, {13'd0, 2'b10, nxt_held1}, KIND_RAW);
			end
			nxt_len = 3'd0;
			nxt_rcv = 2'd0;
			nxt_acc = '0;
		end
	end

	assign bundle = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 3'd0;
			rcv_q <= 2'd0;
			acc_q <= '0;
		end else if (advance) begin
			len_q <= nxt_len;
			rcv_q <= nxt_rcv;
			acc_q <= nxt_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held0_q <= nxt_held0;
			held1_q <= nxt_held1;
		end
	end

	`ASSERT_ALWAYS(a_idle_no_held, (len_q != 3'd0) || (rcv_q == 2'd0), "count held while idle")
	`ASSERT_ALWAYS(a_len_code, (len_q != 3'd1) && (len_q <= 3'd4), "bad sequence length")
	`ASSERT_ALWAYS(a_pending_short, (len_q == 3'd0) || (({1'b0, rcv_q} + 3'd2) <= len_q), "sequence overran its length")

endmodule

// ===== rtl/utf8d_outq.sv =====
// ----------------------------------------------------------------------------
// utf8d_outq
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_outq
	import utf8d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  bundle_t  bundle,
	output logic     free,
	utf8d_out_if.source points
);

	res_t [MAX_RES-1:0] item_s2;
	logic [2:0]         cnt_s2;
	logic               pop;

	assign pop  = points.valid && points.ready;
	assign free = (cnt_s2 == 3'd0) || ((cnt_s2 == 3'd1) && points.ready);

	assign points.valid       = (cnt_s2 != 3'd0);
	assign points.code_point  = item_s2[0].cp;
	assign points.kind        = item_s2[0].kind;
	assign points.last_of_run = (cnt_s2 == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 3'd0;
		end else if (load) begin
			cnt_s2 <= bundle.count;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 3'd1;
		end
	end

	// advance the queue by one beat on each pop
	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= bundle.item;
		end else if (pop) begin
			item_s2 <= {item_s2[MAX_RES-1], item_s2[MAX_RES-1:1]};
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, cnt_s2 <= 3'd4, "result count out of range")
	`ASSERT_ALWAYS(a_load_when_free, !load || free, "results overwritten before delivery")
	`ASSERT_NEXT(a_run_continues, pop && (cnt_s2 > 3'd1), points.valid, "run cut short")

endmodule

// ===== sim/utf8_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Drives text bytes into the UTF-8 decoder and checks every code point beat
// against an in-bench decoder: directed sequences first, then random text
// made mostly of well-formed characters with broken sequences and noise.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
	import utf8d_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       eot;
	} text_byte_t;

	typedef struct {
		logic [CP_W-1:0]   cp;
		logic [KIND_W-1:0] kind;
		logic              last;
	} point_t;

	logic clk;
	logic arst_n;

	utf8d_in_if  text_if();
	utf8d_out_if points_if();

	utf8_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.points (points_if)
	);

	text_byte_t text_bytes[$];
	point_t     expected_points[$];
	point_t     run_points[$];

	// decoder state mirrored from the block
	logic [2:0]      seq_len = 3'd0;
	logic [1:0]      cont_cnt = 2'd0;
	logic [CP_W-1:0] acc = '0;
	logic [5:0]      held [2] = '{6'd0, 6'd0};

	int   errors = 0;
	bit   idle_on = 1'b1;
	bit   long_stall_req = 1'b0;
	logic text_beat = 1'b0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   stall_left = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int rand_gap();
		if (!idle_on)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic add_point(input logic [CP_W-1:0] cp, input logic [KIND_W-1:0] kind);
		point_t p;
		p.cp   = cp;
		p.kind = kind;
		p.last = 1'b0;
		run_points.push_back(p);
	endtask

	task automatic clear_seq();
		seq_len  = 3'd0;
		cont_cnt = 2'd0;
		acc      = '0;
	endtask

	// Replacement first, then each held continuation byte raw.
	task automatic flush_seq();
		add_point(CP_REPLACEMENT, KIND_REPL);
		for (int i = 0; i < int'(cont_cnt) && i < 2; i++)
			add_point({13'd0, 2'b10, held[i]}, KIND_RAW);
		clear_seq();
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eot);
		bit     consumed;
		point_t p;
		consumed = 1'b0;
		run_points.delete();
		if (seq_len != 3'd0) begin
			if (b[7:6] == 2'b10) begin
				acc = {acc[CP_W-7:0], b[5:0]};
				if (int'(cont_cnt) + 2 >= int'(seq_len)) begin
					add_point(acc, KIND_DECODED);
					clear_seq();
				end else begin
					held[cont_cnt[0]] = b[5:0];
					cont_cnt = cont_cnt + 2'd1;
				end
				consumed = 1'b1;
			end else begin
				flush_seq();
			end
		end
		if (!consumed) begin
			if (b[7] == 1'b0) begin
				add_point({13'd0, b}, KIND_DECODED);
			end else if (b[7:5] == 3'b110) begin
				seq_len = 3'd2;
				acc     = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				seq_len = 3'd3;
				acc     = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				seq_len = 3'd4;
				acc     = {18'd0, b[2:0]};
			end else begin
				add_point({13'd0, b}, KIND_RAW);
			end
		end
		if (eot && seq_len != 3'd0)
			flush_seq();
		foreach (run_points[i]) begin
			p      = run_points[i];
			p.last = (i == run_points.size() - 1);
			expected_points.push_back(p);
		end
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic eot);
		text_byte_t t;
		t.data = data;
		t.eot  = eot;
		text_bytes.push_back(t);
	endtask

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			1: return 8'($urandom_range(0, 127));
			2: return 8'hC0 + 8'($urandom_range(0, 31));
			3: return 8'hE0 + 8'($urandom_range(0, 15));
			default: return 8'hF0 + 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 + 8'($urandom_range(0, 63));
	endfunction

	function automatic logic rand_eot();
		return $urandom_range(0, 31) == 0;
	endfunction

	// Mostly whole characters, some cut short by a non-continuation, some noise.
	task automatic queue_random_text(input int count);
		int n;
		int sel;
		int len;
		int k;
		n = 0;
		while (n < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				len = $urandom_range(1, 4);
				queue_byte(lead_byte(len), rand_eot());
				for (int i = 1; i < len; i++)
					queue_byte(cont_byte(), rand_eot());
				n += len;
			end else if (sel < 85) begin
				len = $urandom_range(2, 4);
				k   = $urandom_range(0, len - 2);
				queue_byte(lead_byte(len), rand_eot());
				for (int i = 0; i < k; i++)
					queue_byte(cont_byte(), rand_eot());
				if ($urandom_range(0, 1))
					queue_byte(8'($urandom_range(0, 127)), rand_eot());
				else
					queue_byte(8'($urandom_range(192, 255)), rand_eot());
				n += k + 2;
			end else begin
				queue_byte(8'($urandom_range(0, 255)), rand_eot());
				n++;
			end
		end
	endtask

	task automatic wait_for_text(input bit results_too);
		while (text_bytes.size() != 0 || (results_too && expected_points.size() != 0))
			@(posedge clk);
	endtask

	// Text side: hold the beat until taken, then advance or insert a gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!text_if.valid || text_beat) begin
				if (send_gap > 0) begin
					text_if.valid <= 1'b0;
					send_gap--;
				end else if (text_bytes.size() != 0) begin
					text_if.valid       <= 1'b1;
					text_if.data_byte   <= text_bytes[0].data;
					text_if.end_of_text <= text_bytes[0].eot;
					if ($urandom_range(0, 2) == 0)
						send_gap = rand_gap();
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left     = 200;
			end
			if (stall_left > 0) begin
				points_if.ready <= 1'b0;
				stall_left--;
			end else if (recv_gap > 0) begin
				points_if.ready <= 1'b0;
				recv_gap--;
			end else begin
				points_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap = rand_gap();
			end
		end
	end

	always @(posedge clk) begin : monitor
		point_t want;
		if (arst_n) begin
			text_beat <= text_if.valid && text_if.ready;
			if (text_if.valid && text_if.ready) begin
				decode_byte(text_if.data_byte, text_if.end_of_text);
				text_bytes.pop_front();
			end
			if (points_if.valid && points_if.ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected beat: cp=%h kind=%0d last=%b", $time,
						points_if.code_point, points_if.kind, points_if.last_of_run);
					errors++;
				end else begin
					want = expected_points.pop_front();
					if (points_if.code_point !== want.cp) begin
						$display("%0t: code_point expected %h actual %h", $time,
							want.cp, points_if.code_point);
						errors++;
					end
					if (points_if.kind !== want.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time,
							want.kind, points_if.kind);
						errors++;
					end
					if (points_if.last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %b actual %b", $time,
							want.last, points_if.last_of_run);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		arst_n                = 1'b0;
		text_if.valid         = 1'b0;
		text_if.data_byte     = 8'h00;
		text_if.end_of_text   = 1'b0;
		points_if.ready       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ASCII extremes, including the zero byte
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		// two, three and four byte characters, the last one the largest 21-bit value
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF7, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		// stray continuation and bytes that cannot lead
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hF8, 1'b0);
		queue_byte(8'hFF, 1'b0);
		// broken four byte sequence: replacement, two raw bytes, then the ASCII
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h41, 1'b0);
		// broken by a new lead, which then completes
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hA9, 1'b0);
		// end of text mid-sequence, and on a lead byte
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);
		queue_byte(8'hC3, 1'b1);
		wait_for_text(1'b1);

		// Receiver holds off while the sender streams with no gaps.
		idle_on        = 1'b0;
		long_stall_req = 1'b1;
		queue_random_text(34);
		wait_for_text(1'b0);
		idle_on = 1'b1;
		queue_random_text(34);
		wait_for_text(1'b1);
		idle_on = 1'b0;
		queue_random_text(34);
		wait_for_text(1'b0);
		idle_on = 1'b1;
		queue_random_text(34);
		wait_for_text(1'b1);

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
